// ===== sv/mcrs_pkg.sv =====
`default_nettype none

package mcrs_pkg;

    // Store geometry.
    localparam int CAPACITY = 128;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Field widths on the channels.
    localparam int OP_W    = 2;
    localparam int VALUE_W = 32;
    localparam int OUT_W   = 8;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_COUNT  = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    // Status codes.
    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FULL = 1'b1;

    // Access request from the sequencer to the value memory.
    typedef struct packed {
        logic               we;
        logic [IDX_W-1:0]   waddr;
        logic [VALUE_W-1:0] wdata;
        logic               re;
        logic [IDX_W-1:0]   raddr;
    } mcrs_mem_req_t;

endpackage

`default_nettype wire

// ===== sv/mcrs_chan_if.sv =====
`default_nettype none

// Request channel: one operation on the multiset.
interface mcrs_req_if
    import mcrs_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           operation;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

// Response channel: one result per operation.
interface mcrs_rsp_if
    import mcrs_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] match_count;
    logic [OUT_W-1:0] fill_count;
    logic             status;

    modport source (output valid, output match_count, output fill_count, output status,
                    input ready);
    modport sink   (input valid, input match_count, input fill_count, input status,
                    output ready);
endinterface

`default_nettype wire

// ===== sv/mcrs_ram.sv =====
`default_nettype none

module mcrs_ram
    import mcrs_pkg::*;
(
    input  wire logic               clk,
    input  wire mcrs_mem_req_t      req,
    output logic [VALUE_W-1:0]      rdata
);

    logic [VALUE_W-1:0] mem [CAPACITY];
    logic [VALUE_W-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // Registered read port; a write to the same entry in the same cycle is forwarded.
    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            if (req.we && (req.waddr == req.raddr))
            begin
                rdata_reg <= req.wdata;
            end
            else
            begin
                rdata_reg <= mem[req.raddr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== sv/mcrs_ctrl.sv =====
`default_nettype none

module mcrs_ctrl
    import mcrs_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [OP_W-1:0]     in_op,
    input  wire logic [VALUE_W-1:0]  in_value,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [OUT_W-1:0]         out_match,
    output logic [OUT_W-1:0]         out_fill,
    output logic                     out_status,
    output mcrs_mem_req_t            mem_req,
    input  wire logic [VALUE_W-1:0]  mem_rdata
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_MOVE = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]         state_reg,  state_next;
    logic [OP_W-1:0]    op_reg,     op_next;
    logic [VALUE_W-1:0] value_reg,  value_next;
    logic [IDX_W-1:0]   idx_reg,    idx_next;
    logic [CNT_W-1:0]   cnt_reg,    cnt_next;
    logic [CNT_W-1:0]   match_reg,  match_next;
    logic               status_reg, status_next;

    logic               out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]   out_match_reg, out_match_next;
    logic [OUT_W-1:0]   out_fill_reg,  out_fill_next;
    logic               out_status_reg, out_status_next;

    logic               hit;
    logic [CNT_W-1:0]   idx_ext;
    logic [CNT_W-1:0]   idx_inc;
    logic [CNT_W-1:0]   cnt_m1;
    logic [CNT_W-1:0]   cnt_m2;
    logic               accept;
    logic               out_free;

    // Helpers for the walk over the filled part of the store.
    assign hit      = (mem_rdata == value_reg);
    assign idx_ext  = CNT_W'(idx_reg);
    assign idx_inc  = idx_ext + 1'b1;
    assign cnt_m1   = cnt_reg - 1'b1;
    assign cnt_m2   = cnt_reg - 2'd2;
    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // Sequencer: read, compare and move entries, with at most one read and one write of the value memory per step.
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        value_next      = value_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        match_next      = match_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_match_next  = out_match_reg;
        out_fill_next   = out_fill_reg;
        out_status_next = out_status_reg;
        mem_req         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next     = in_op;
                    value_next  = in_value;
                    idx_next    = '0;
                    match_next  = '0;
                    status_next = ST_OK;
                    state_next  = S_DONE;
                    case (in_op)
                        OP_INSERT:
                        begin
                            if (cnt_reg < CNT_W'(CAPACITY))
                            begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = cnt_reg[IDX_W-1:0];
                                mem_req.wdata = in_value;
                                cnt_next      = cnt_reg + 1'b1;
                            end
                            else
                            begin
                                status_next = ST_FULL;
                            end
                        end
                        OP_COUNT, OP_REMOVE:
                        begin
                            if (cnt_reg != '0)
                            begin
                                mem_req.re    = 1'b1;
                                mem_req.raddr = '0;
                                state_next    = S_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // Read data holds the entry at idx_reg.
                if (hit && (op_reg == OP_REMOVE))
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = cnt_m1[IDX_W-1:0];
                    state_next    = S_MOVE;
                end
                else
                begin
                    if (hit)
                    begin
                        match_next = match_reg + 1'b1;
                    end
                    if (idx_inc < cnt_reg)
                    begin
                        idx_next      = idx_inc[IDX_W-1:0];
                        mem_req.re    = 1'b1;
                        mem_req.raddr = idx_inc[IDX_W-1:0];
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_MOVE:
            begin
                // Read data holds the last entry; it fills the freed slot.
                mem_req.we    = 1'b1;
                mem_req.waddr = idx_reg;
                mem_req.wdata = mem_rdata;
                cnt_next      = cnt_m1;
                match_next    = match_reg + 1'b1;
                if (hit && (idx_ext < cnt_m1))
                begin
                    // The moved entry matches too: fetch the new last entry.
                    mem_req.re    = 1'b1;
                    mem_req.raddr = cnt_m2[IDX_W-1:0];
                end
                else if (!hit && (idx_inc < cnt_m1))
                begin
                    idx_next      = idx_inc[IDX_W-1:0];
                    mem_req.re    = 1'b1;
                    mem_req.raddr = idx_inc[IDX_W-1:0];
                    state_next    = S_SCAN;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_match_next  = OUT_W'(match_reg);
                    out_fill_next   = OUT_W'(cnt_reg);
                    out_status_next = status_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and result payload.
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        value_reg      <= value_next;
        idx_reg        <= idx_next;
        match_reg      <= match_next;
        status_reg     <= status_next;
        out_match_reg  <= out_match_next;
        out_fill_reg   <= out_fill_next;
        out_status_reg <= out_status_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_match  = out_match_reg;
    assign out_fill   = out_fill_reg;
    assign out_status = out_status_reg;

endmodule

`default_nettype wire

// ===== sv/multiset_count_remove_store.sv =====
`default_nettype none

// Channel | Role   | Payload
// --------+--------+-------------------------------------------
// req     | sink   | operation[1:0], value[31:0] signed
// rsp     | source | match_count[7:0], fill_count[7:0], status
//
// An insert writes its value when the item is accepted and goes straight to the final
// step, which offers the result. A count and a remove walk the filled entries one by
// one, because every entry passes through the single read port of the value memory one access at
// a time. The next item is accepted in the cycle the result is offered.
// Reset clears the fill count and the sequencer; stored values need no clearing.
// A result waits in the output register while the next item is accepted; that item
// then holds in its final step until the waiting result is taken.
module multiset_count_remove_store
    import mcrs_pkg::*;
(
    input wire logic   clk,
    input wire logic   rst_n,
    mcrs_req_if.sink   req,
    mcrs_rsp_if.source rsp
);

    mcrs_mem_req_t      mem_req;
    logic [VALUE_W-1:0] mem_rdata;

    // Sequencer and fill count.
    mcrs_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (req.valid),
        .in_ready   (req.ready),
        .in_op      (req.operation),
        .in_value   (req.value),
        .out_valid  (rsp.valid),
        .out_ready  (rsp.ready),
        .out_match  (rsp.match_count),
        .out_fill   (rsp.fill_count),
        .out_status (rsp.status),
        .mem_req    (mem_req),
        .mem_rdata  (mem_rdata)
    );

    // Value store.
    mcrs_ram u_ram (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

endmodule

`default_nettype wire

// ===== sv/mcrs_checker.sv =====
`default_nettype none

module mcrs_checker
    import mcrs_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             rsp_valid,
    input wire logic             rsp_ready,
    input wire logic [OUT_W-1:0] rsp_match_count,
    input wire logic [OUT_W-1:0] rsp_fill_count,
    input wire logic             rsp_status
);

    // A result that is not taken stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> rsp_valid)
        else $error("result withdrawn before it was taken");

    // The fill count never exceeds the store.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_fill_count <= OUT_W'(CAPACITY)))
        else $error("fill count beyond capacity");

    // A dropped insert reports a full store.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_status == ST_FULL)) |-> (rsp_fill_count == OUT_W'(CAPACITY)))
        else $error("full status with a store that is not full");

    // A dropped insert matches nothing.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_status == ST_FULL)) |-> (rsp_match_count == '0))
        else $error("full status with a nonzero match count");

endmodule

bind multiset_count_remove_store mcrs_checker u_mcrs_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_match_count (rsp.match_count),
    .rsp_fill_count  (rsp.fill_count),
    .rsp_status      (rsp.status)
);

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import mcrs_pkg::*;

    // The one code the package leaves unnamed; the block must treat it as a no-op.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int POOL_SIZE = 8;
    localparam int DRAIN_CYCLES = 2 * CAPACITY + 10;

    typedef struct {
        logic [OP_W-1:0]           op;
        logic signed [VALUE_W-1:0] value;
    } bag_op_t;

    typedef struct {
        logic [OUT_W-1:0] match_count;
        logic [OUT_W-1:0] fill_count;
        logic             status;
    } bag_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    mcrs_req_if req_ch ();
    mcrs_rsp_if rsp_ch ();

    multiset_count_remove_store dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    // Pending operations, expected results and the shadow copy of the bag.
    bag_op_t          pending_ops [$];
    bag_result_t      result_q [$];
    logic [VALUE_W-1:0] bag_store [CAPACITY];
    int               bag_fill;
    logic [VALUE_W-1:0] value_pool [POOL_SIZE];

    int snd_idle_pct;
    int rcv_idle_pct;
    int err_cnt;
    int ops_accepted;
    int results_checked;
    int full_drops;
    int remove_hits;

    // Free-running clock, 8 ns period.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Apply one operation to the shadow bag and return the result it should produce.
    function automatic bag_result_t bag_apply(bag_op_t item);
        bag_result_t res;
        int          hits;
        int          i;
        hits = 0;
        res.status = ST_OK;
        case (item.op)
            OP_INSERT:
            begin
                if (bag_fill < CAPACITY)
                begin
                    bag_store[bag_fill] = item.value;
                    bag_fill++;
                end
                else
                begin
                    res.status = ST_FULL;
                end
            end
            OP_COUNT:
            begin
                for (i = 0; i < bag_fill; i++)
                begin
                    if (bag_store[i] == item.value)
                        hits++;
                end
            end
            OP_REMOVE:
            begin
                // The last entry moves into the freed slot, which is then checked again.
                i = 0;
                while (i < bag_fill)
                begin
                    if (bag_store[i] == item.value)
                    begin
                        bag_store[i] = bag_store[bag_fill - 1];
                        bag_fill--;
                        hits++;
                    end
                    else
                    begin
                        i++;
                    end
                end
            end
            default:
            begin
            end
        endcase
        res.match_count = OUT_W'(hits);
        res.fill_count  = OUT_W'(bag_fill);
        return res;
    endfunction

    // Request driver: record each accepted item, then offer the next one or idle.
    always @(posedge clk or negedge rst_n)
    begin : req_driver
        bag_op_t     nxt;
        bag_result_t res;
        if (!rst_n)
        begin
            req_ch.valid     <= 1'b0;
            req_ch.operation <= OP_INSERT;
            req_ch.value     <= '0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                nxt.op    = req_ch.operation;
                nxt.value = req_ch.value;
                res = bag_apply(nxt);
                result_q.push_back(res);
                ops_accepted++;
                if (nxt.op == OP_REMOVE && res.match_count != 0)
                    remove_hits++;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (pending_ops.size() != 0 && $urandom_range(99) >= snd_idle_pct)
                begin
                    nxt = pending_ops.pop_front();
                    req_ch.valid     <= 1'b1;
                    req_ch.operation <= nxt.op;
                    req_ch.value     <= nxt.value;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare each accepted result with the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin : rsp_monitor
        bag_result_t exp_res;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (result_q.size() == 0)
                begin
                    $error("result with no operation outstanding: match_count %0d fill_count %0d",
                           rsp_ch.match_count, rsp_ch.fill_count);
                    err_cnt++;
                end
                else
                begin
                    exp_res = result_q.pop_front();
                    results_checked++;
                    if (exp_res.status == ST_FULL)
                        full_drops++;
                    if (rsp_ch.match_count !== exp_res.match_count)
                    begin
                        $error("match_count: expected %0d, got %0d",
                               exp_res.match_count, rsp_ch.match_count);
                        err_cnt++;
                    end
                    if (rsp_ch.fill_count !== exp_res.fill_count)
                    begin
                        $error("fill_count: expected %0d, got %0d",
                               exp_res.fill_count, rsp_ch.fill_count);
                        err_cnt++;
                    end
                    if (rsp_ch.status !== exp_res.status)
                    begin
                        $error("status: expected %0d, got %0d", exp_res.status, rsp_ch.status);
                        err_cnt++;
                    end
                end
            end
            rsp_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    task automatic push_op(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value);
        bag_op_t item;
        item.op    = op;
        item.value = value;
        pending_ops.push_back(item);
    endtask

    // Refill the value pool; extremes show up often so they collide in the store.
    task automatic refresh_pool();
        int k;
        for (k = 0; k < POOL_SIZE; k++)
        begin
            case ($urandom_range(9))
                0: value_pool[k] = 32'h8000_0000;
                1: value_pool[k] = 32'h7fff_ffff;
                2: value_pool[k] = 32'h0000_0000;
                3: value_pool[k] = 32'hffff_ffff;
                default: value_pool[k] = $urandom;
            endcase
        end
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        if ($urandom_range(99) < 85)
            return value_pool[$urandom_range(POOL_SIZE - 1)];
        return $urandom;
    endfunction

    // Mostly pool-based operations so counts and removes find matches, with
    // occasional long insert bursts that run the store into its full state.
    task automatic queue_random(int n_items);
        int queued;
        int burst;
        int r;
        int k;
        queued = 0;
        while (queued < n_items)
        begin
            if (queued % 50 == 0)
                refresh_pool();
            r = $urandom_range(99);
            if (r < 45)
            begin
                push_op(OP_INSERT, pick_value());
                queued++;
            end
            else if (r < 72)
            begin
                push_op(OP_COUNT, pick_value());
                queued++;
            end
            else if (r < 92)
            begin
                push_op(OP_REMOVE, pick_value());
                queued++;
            end
            else if (r < 98)
            begin
                push_op(OP_UNUSED, $urandom);
                queued++;
            end
            else
            begin
                burst = $urandom_range(CAPACITY - 20, CAPACITY + 12);
                for (k = 0; k < burst; k++)
                    push_op(OP_INSERT, pick_value());
                push_op(OP_COUNT, pick_value());
                queued += burst + 1;
            end
        end
    endtask

    // Wait until every queued item is accepted and every result has arrived.
    task automatic wait_idle();
        @(negedge clk);
        while (pending_ops.size() != 0 || req_ch.valid || result_q.size() != 0)
            @(negedge clk);
    endtask

    // Main sequence.
    initial
    begin
        req_ch.valid     = 1'b0;
        req_ch.operation = OP_INSERT;
        req_ch.value     = '0;
        rsp_ch.ready     = 1'b0;
        bag_fill         = 0;
        err_cnt          = 0;
        ops_accepted     = 0;
        results_checked  = 0;
        full_drops       = 0;
        remove_hits      = 0;
        snd_idle_pct     = 25;
        rcv_idle_pct     = 49;
        refresh_pool();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty store, extremes, a remove whose moved-in entry also
        // matches, the unused code, and draining the store back to empty.
        push_op(OP_COUNT, 32'h0000_0000);
        push_op(OP_REMOVE, 32'h0000_0000);
        push_op(OP_INSERT, 32'd5);
        push_op(OP_INSERT, 32'd7);
        push_op(OP_INSERT, 32'd5);
        push_op(OP_INSERT, 32'd5);
        push_op(OP_REMOVE, 32'd5);
        push_op(OP_COUNT, 32'd7);
        push_op(OP_INSERT, 32'h8000_0000);
        push_op(OP_INSERT, 32'h7fff_ffff);
        push_op(OP_INSERT, 32'hffff_ffff);
        push_op(OP_INSERT, 32'h0000_0000);
        push_op(OP_INSERT, 32'h8000_0000);
        push_op(OP_COUNT, 32'h8000_0000);
        push_op(OP_COUNT, 32'h7fff_ffff);
        push_op(OP_COUNT, 32'd1);
        push_op(OP_UNUSED, 32'h7fff_ffff);
        push_op(OP_UNUSED, 32'h8000_0000);
        push_op(OP_REMOVE, 32'h8000_0000);
        push_op(OP_COUNT, 32'h8000_0000);
        push_op(OP_REMOVE, 32'd7);
        push_op(OP_REMOVE, 32'hffff_ffff);
        push_op(OP_REMOVE, 32'h0000_0000);
        push_op(OP_REMOVE, 32'h7fff_ffff);
        wait_idle();

        // Full store right away, so an overflowing insert is seen early.
        for (int k = 0; k < CAPACITY + 3; k++)
            push_op(OP_INSERT, pick_value());
        push_op(OP_COUNT, value_pool[0]);
        push_op(OP_REMOVE, value_pool[1]);
        queue_random(200);
        wait_idle();

        snd_idle_pct = 49;
        rcv_idle_pct = 25;
        queue_random(330);
        wait_idle();

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        queue_random(330);
        wait_idle();

        // Let any stray result show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d operations, checked %0d results (%0d full-store drops, %0d removes with hits)",
                 ops_accepted, results_checked, full_drops, remove_hits);
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #20000000;
        $display("Timeout with %0d items pending and %0d results outstanding",
                 pending_ops.size(), result_q.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
